// ===== rtl/put_exercise_policy_eval_defines.svh =====
// Assertion macros for the put exercise policy evaluator.
// Included by the top level; relies on i_clk and i_rst_n in the including scope.
`ifndef PUT_EXERCISE_POLICY_EVAL_DEFINES_SVH
`define PUT_EXERCISE_POLICY_EVAL_DEFINES_SVH

// same-cycle implication, held off during reset
`define PEP_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define PEP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/pep_pkg.sv =====
// Shared types, codes and helpers of the put exercise policy evaluator.
// No dependencies.
`timescale 1ns / 1ps

package pep_pkg;

    // default sizes
    localparam int MAX_STEPS_DEF  = 256;
    localparam int MAX_DEGREE_DEF = 8;
    localparam int FRAC_BITS_DEF  = 16;

    // datapath widths
    localparam int MUL_W      = 34;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int SCALE_FRAC = 30;
    // divider input saturates once the magnitude reaches 2^36 (divisor fits in 5 bits)
    localparam int DIV_W      = 36;
    localparam int DVS_W      = 5;

    // item actions
    localparam logic [1:0] ACT_COEF   = 2'd0;
    localparam logic [1:0] ACT_DISC   = 2'd1;
    localparam logic [1:0] ACT_SAMPLE = 2'd2;

    // register indexes
    localparam logic [2:0] REG_STRIKE   = 3'd0;
    localparam logic [2:0] REG_RECIP    = 3'd1;
    localparam logic [2:0] REG_SCALE    = 3'd2;
    localparam logic [2:0] REG_DEGREE   = 3'd3;
    localparam logic [2:0] REG_SELECT   = 3'd4;
    localparam logic [2:0] REG_TERMINAL = 3'd5;

    typedef struct packed {
        logic [1:0]         action;
        logic [8:0]         step_index;
        logic [3:0]         coef_index;
        logic signed [31:0] coefficient;
        logic [31:0]        amount;
        logic               path_end;
    } t_in;

    typedef struct packed {
        logic [31:0] discounted_payoff;
        logic [8:0]  exercise_step;
    } t_out;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_sts;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PRICE,
        ST_PAYOFF,
        ST_ARG,
        ST_X,
        ST_DOT,
        ST_ACC,
        ST_BNEXT,
        ST_DIV,
        ST_CMP,
        ST_FINISH,
        ST_DISC,
        ST_EMIT
    } t_state;

    // saturate a wide signed value to the int32 range
    function automatic logic signed [31:0] clamp32(input logic signed [PROD_W-1:0] v);
        logic signed [PROD_W-1:0] hi;
        logic signed [PROD_W-1:0] lo;
        hi = PROD_W'(32'sh7FFF_FFFF);
        lo = -PROD_W'(33'sh0_8000_0000);
        if (v > hi) begin
            clamp32 = 32'sh7FFF_FFFF;
        end else if (v < lo) begin
            clamp32 = 32'sh8000_0000;
        end else begin
            clamp32 = 32'(v);
        end
    endfunction

endpackage

// ===== rtl/pep_div.sv =====
// Bit-serial restoring divider for the Laguerre recurrence quotient.
// Depends on pep_pkg for widths and the status struct.
`timescale 1ns / 1ps

module pep_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [pep_pkg::DIV_W-1:0] i_dividend,
    input  logic [pep_pkg::DVS_W-1:0] i_divisor,
    output pep_pkg::t_div_sts         o_sts,
    output logic [pep_pkg::DIV_W-1:0] o_quot
);

    localparam int CW = $clog2(pep_pkg::DIV_W);

    logic [pep_pkg::DIV_W-1:0] r_dvd, n_dvd;
    logic [pep_pkg::DVS_W-1:0] r_dvs, n_dvs;
    logic [pep_pkg::DVS_W-1:0] r_rem, n_rem;
    logic [CW-1:0]             r_cnt, n_cnt;
    logic                      r_busy, n_busy;
    logic                      r_done, n_done;
    logic [pep_pkg::DVS_W:0]   trial;
    logic                      ge;

    // one quotient bit per cycle, MSB first
    always_comb begin
        trial  = {r_rem, r_dvd[pep_pkg::DIV_W-1]};
        ge     = trial >= {1'b0, r_dvs};
        n_dvd  = r_dvd;
        n_dvs  = r_dvs;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_dvd  = i_dividend;
            n_dvs  = i_divisor;
            n_rem  = '0;
            n_cnt  = CW'(pep_pkg::DIV_W - 1);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_dvd = {r_dvd[pep_pkg::DIV_W-2:0], ge};
            n_rem = ge ? pep_pkg::DVS_W'(trial - {1'b0, r_dvs})
                       : trial[pep_pkg::DVS_W-1:0];
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_dvd <= n_dvd;
        r_dvs <= n_dvs;
        r_rem <= n_rem;
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_quot     = r_dvd;

endmodule

// ===== rtl/put_exercise_policy_eval.sv =====
// Top level of the put exercise policy evaluator: APB registers, tables,
// sequencer with one shared multiplier, and the Laguerre divider.
// Depends on pep_pkg, pep_div and put_exercise_policy_eval_defines.svh.
`timescale 1ns / 1ps

// Bermudan put policy evaluator. Coefficient and discount loads are written
// into their tables as they are accepted. A price sample passes the price,
// payoff and finish states, and a path_end sample also the discount and emit
// states to emit the discounted payoff. A sample evaluated against the policy
// adds the argument, x and compare states, plus dot, accumulate and next-basis
// steps per basis term; each Laguerre term above 1 also waits on the bit-serial
// divider (36 quotient bits, one per cycle). All products share one 34x34 multiplier.
// in_stall is high while an item is in work; the result sits in an output
// register so the next item can be taken while it waits.
`include "put_exercise_policy_eval_defines.svh"

module put_exercise_policy_eval #(
    parameter int MAX_STEPS  = pep_pkg::MAX_STEPS_DEF,
    parameter int MAX_DEGREE = pep_pkg::MAX_DEGREE_DEF,
    parameter int FRAC_BITS  = pep_pkg::FRAC_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  pep_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output pep_pkg::t_out o_out_data,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [4:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    localparam int TERMS = MAX_DEGREE + 1;
    localparam int AW    = $clog2(MAX_STEPS * TERMS);
    localparam int DAW   = $clog2(MAX_STEPS + 1);
    localparam int SW    = $clog2(MAX_STEPS);
    localparam int JW    = $clog2(MAX_DEGREE + 2);
    localparam int PW    = pep_pkg::PROD_W;
    localparam int MW    = pep_pkg::MUL_W;

    // configuration registers
    logic [31:0] r_strike, r_recip, r_scale;
    logic [3:0]  r_degree;
    logic        r_select;
    logic [8:0]  r_terminal;

    // tables
    logic signed [31:0] coef_mem [MAX_STEPS * TERMS];
    logic [31:0]        disc_mem [MAX_STEPS + 1];
    logic [MAX_STEPS-1:0] r_valid;
    logic signed [31:0] r_coef_rd;
    logic [31:0]        r_disc_rd;

    // sequencer and datapath
    pep_pkg::t_state    r_state, n_state;
    pep_pkg::t_in       r_item;
    logic signed [PW-1:0] r_prod, n_prod;
    logic [31:0]        r_s, n_s, r_payoff, n_payoff;
    logic signed [31:0] r_x, n_x, r_bcur, n_bcur, r_bprev, n_bprev;
    logic signed [63:0] r_cont, n_cont;
    logic [JW-1:0]      r_j, n_j;
    logic [31:0]        r_cash, n_cash;
    logic [8:0]         r_exstep, n_exstep;
    logic               r_tneg, n_tneg;
    logic               r_out_valid, n_out_valid;
    pep_pkg::t_out      r_out_data, n_out_data;

    logic               in_acc;
    logic               coef_we;
    logic               disc_we;
    logic [AW-1:0]      coef_waddr, coef_base, coef_raddr;
    logic [JW-1:0]      d_lim;
    logic signed [MW-1:0] m_a, m_b;
    logic               mul_go;
    logic signed [PW-1:0] prod_sh, t_val, t_mag, q_val;
    logic               div_start;
    logic [pep_pkg::DIV_W-1:0] div_dvd, div_quot;
    pep_pkg::t_div_sts  div_sts;
    logic               eligible;
    logic               cfg_we;

    assign in_acc = i_in_valid && !o_in_stall;

    // APB register port
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strike   <= 32'd6553600;
            r_recip    <= 32'd655;
            r_scale    <= 32'd1073741824;
            r_degree   <= 4'd2;
            r_select   <= 1'b1;
            r_terminal <= 9'd50;
        end else if (cfg_we) begin
            unique case (paddr[4:2])
                pep_pkg::REG_STRIKE:   r_strike   <= pwdata;
                pep_pkg::REG_RECIP:    r_recip    <= pwdata;
                pep_pkg::REG_SCALE:    r_scale    <= pwdata;
                pep_pkg::REG_DEGREE:   r_degree   <= pwdata[3:0];
                pep_pkg::REG_SELECT:   r_select   <= pwdata[0];
                pep_pkg::REG_TERMINAL: r_terminal <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            pep_pkg::REG_STRIKE:   prdata = r_strike;
            pep_pkg::REG_RECIP:    prdata = r_recip;
            pep_pkg::REG_SCALE:    prdata = r_scale;
            pep_pkg::REG_DEGREE:   prdata = {28'd0, r_degree};
            pep_pkg::REG_SELECT:   prdata = {31'd0, r_select};
            pep_pkg::REG_TERMINAL: prdata = {23'd0, r_terminal};
            default:               prdata = '0;
        endcase
    end

    // load decode
    assign coef_we = in_acc && (i_in_data.action == pep_pkg::ACT_COEF) &&
                     (int'(i_in_data.step_index) < MAX_STEPS) &&
                     (int'(i_in_data.coef_index) <= MAX_DEGREE);
    assign disc_we = in_acc && (i_in_data.action == pep_pkg::ACT_DISC) &&
                     (int'(i_in_data.step_index) <= MAX_STEPS);
    assign coef_waddr = AW'(AW'(i_in_data.step_index) * AW'(TERMS) +
                            AW'(i_in_data.coef_index));
    assign coef_base  = AW'(AW'(r_item.step_index) * AW'(TERMS));
    assign coef_raddr = AW'(coef_base + AW'(n_j));

    // coefficient memory: one write port, one registered read
    always_ff @(posedge i_clk) begin
        if (coef_we) begin
            coef_mem[coef_waddr] <= i_in_data.coefficient;
        end
        r_coef_rd <= coef_mem[coef_raddr];
    end

    // discount memory, read at the recorded exercise step
    always_ff @(posedge i_clk) begin
        if (disc_we) begin
            disc_mem[DAW'(i_in_data.step_index)] <= i_in_data.amount;
        end
        r_disc_rd <= disc_mem[DAW'(r_exstep)];
    end

    // step valid marks
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (coef_we) begin
            r_valid[SW'(i_in_data.step_index)] <= 1'b1;
        end
    end

    assign d_lim = (int'(r_degree) > MAX_DEGREE) ? JW'(MAX_DEGREE) : JW'(r_degree);
    assign prod_sh = r_prod >>> FRAC_BITS;
    assign eligible = (r_item.step_index >= 9'd1) && (r_item.step_index < r_terminal) &&
                      (int'(r_item.step_index) < MAX_STEPS) &&
                      r_valid[SW'(r_item.step_index)] && (n_payoff != 32'd0);

    // Laguerre recurrence numerator and its clipped magnitude
    assign t_val = prod_sh - PW'($signed({1'b0, r_j})) * PW'(r_bprev);
    assign t_mag = (t_val < 0) ? -t_val : t_val;
    assign div_dvd = (t_mag[PW-1:pep_pkg::DIV_W] != '0) ? '1
                                                        : t_mag[pep_pkg::DIV_W-1:0];
    assign q_val = r_tneg ? -PW'($signed({1'b0, div_quot}))
                          : PW'($signed({1'b0, div_quot}));

    pep_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (pep_pkg::DVS_W'(r_j) + pep_pkg::DVS_W'(1)),
        .o_sts      (div_sts),
        .o_quot     (div_quot)
    );

    // sequencer: next state, shared multiplier operands, datapath updates
    always_comb begin
        n_state     = r_state;
        n_s         = r_s;
        n_payoff    = r_payoff;
        n_x         = r_x;
        n_bcur      = r_bcur;
        n_bprev     = r_bprev;
        n_cont      = r_cont;
        n_j         = r_j;
        n_cash      = r_cash;
        n_exstep    = r_exstep;
        n_tneg      = r_tneg;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_data  = r_out_data;
        m_a         = '0;
        m_b         = '0;
        mul_go      = 1'b0;
        div_start   = 1'b0;
        unique case (r_state)
            pep_pkg::ST_IDLE: begin
                if (in_acc && i_in_data.action == pep_pkg::ACT_SAMPLE) begin
                    n_state = pep_pkg::ST_PRICE;
                end
            end
            pep_pkg::ST_PRICE: begin
                m_a     = $signed({2'b00, r_item.amount});
                m_b     = $signed({2'b00, r_scale});
                mul_go  = 1'b1;
                n_state = pep_pkg::ST_PAYOFF;
            end
            pep_pkg::ST_PAYOFF: begin
                n_s = (r_prod[PW-1:32 + pep_pkg::SCALE_FRAC] != '0) ? '1
                      : r_prod[31 + pep_pkg::SCALE_FRAC:pep_pkg::SCALE_FRAC];
                n_payoff = (r_strike > n_s) ? r_strike - n_s : 32'd0;
                if (r_item.step_index == r_terminal) begin
                    n_cash   = n_payoff;
                    n_exstep = r_terminal;
                    n_state  = pep_pkg::ST_FINISH;
                end else if (eligible) begin
                    n_state = pep_pkg::ST_ARG;
                end else begin
                    n_state = pep_pkg::ST_FINISH;
                end
            end
            pep_pkg::ST_ARG: begin
                m_a     = $signed({2'b00, r_s});
                m_b     = $signed({2'b00, r_recip});
                mul_go  = 1'b1;
                n_state = pep_pkg::ST_X;
            end
            pep_pkg::ST_X: begin
                n_x     = pep_pkg::clamp32(prod_sh);
                n_bcur  = 32'sd1 <<< FRAC_BITS;
                n_bprev = '0;
                n_cont  = '0;
                n_j     = '0;
                n_state = pep_pkg::ST_DOT;
            end
            pep_pkg::ST_DOT: begin
                m_a     = MW'(r_coef_rd);
                m_b     = MW'(r_bcur);
                mul_go  = 1'b1;
                n_state = pep_pkg::ST_ACC;
            end
            pep_pkg::ST_ACC: begin
                n_cont = r_cont + 64'(prod_sh);
                if (r_j == d_lim) begin
                    n_state = pep_pkg::ST_CMP;
                end else begin
                    // launch the next basis product while accumulating
                    m_a     = r_select ? (MW'({r_j, 1'b1}) <<< FRAC_BITS) - MW'(r_x)
                                       : MW'(r_x);
                    m_b     = MW'(r_bcur);
                    mul_go  = 1'b1;
                    n_state = pep_pkg::ST_BNEXT;
                end
            end
            pep_pkg::ST_BNEXT: begin
                if (r_select && r_j != '0) begin
                    n_tneg    = t_val < 0;
                    div_start = 1'b1;
                    n_state   = pep_pkg::ST_DIV;
                end else begin
                    n_bcur  = r_select
                              ? pep_pkg::clamp32((PW'(1) <<< FRAC_BITS) - PW'(r_x))
                              : pep_pkg::clamp32(prod_sh);
                    n_bprev = r_bcur;
                    n_j     = r_j + 1'b1;
                    n_state = pep_pkg::ST_DOT;
                end
            end
            pep_pkg::ST_DIV: begin
                if (div_sts.done) begin
                    n_bcur  = pep_pkg::clamp32(q_val);
                    n_bprev = r_bcur;
                    n_j     = r_j + 1'b1;
                    n_state = pep_pkg::ST_DOT;
                end
            end
            pep_pkg::ST_CMP: begin
                if ($signed({32'd0, r_payoff}) > r_cont) begin
                    n_cash   = r_payoff;
                    n_exstep = r_item.step_index;
                end
                n_state = pep_pkg::ST_FINISH;
            end
            pep_pkg::ST_FINISH: begin
                n_state = r_item.path_end ? pep_pkg::ST_DISC : pep_pkg::ST_IDLE;
            end
            pep_pkg::ST_DISC: begin
                m_a     = $signed({2'b00, r_cash});
                m_b     = (int'(r_exstep) <= MAX_STEPS) ? $signed({2'b00, r_disc_rd}) : '0;
                mul_go  = 1'b1;
                n_state = pep_pkg::ST_EMIT;
            end
            pep_pkg::ST_EMIT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_data.discounted_payoff =
                        (prod_sh[PW-1:32] != '0) ? '1 : prod_sh[31:0];
                    n_out_data.exercise_step = r_exstep;
                    n_state = pep_pkg::ST_IDLE;
                end
            end
            default: n_state = pep_pkg::ST_IDLE;
        endcase
        n_prod = mul_go ? m_a * m_b : r_prod;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pep_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
            r_cash      <= '0;
            r_exstep    <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_cash      <= n_cash;
            r_exstep    <= n_exstep;
        end
        if (in_acc) begin
            r_item <= i_in_data;
        end
        r_prod     <= n_prod;
        r_s        <= n_s;
        r_payoff   <= n_payoff;
        r_x        <= n_x;
        r_bcur     <= n_bcur;
        r_bprev    <= n_bprev;
        r_cont     <= n_cont;
        r_j        <= n_j;
        r_tneg     <= n_tneg;
        r_out_data <= n_out_data;
    end

    assign o_in_stall  = r_state != pep_pkg::ST_IDLE;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // checks
    `PEP_ASSERT_NEXT(a_sample_start, in_acc && i_in_data.action == pep_pkg::ACT_SAMPLE, r_state == pep_pkg::ST_PRICE, "sample beat did not start the sequencer")
    `PEP_ASSERT_SAME(a_div_owner, div_sts.busy, r_state == pep_pkg::ST_DIV, "divider busy outside the divide state")
    `PEP_ASSERT_SAME(a_term_bound, r_state == pep_pkg::ST_DOT, r_j <= d_lim, "basis term index beyond degree")

endmodule
